// ----- hdl/psd_pkg.sv -----
`default_nettype none
package psd_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_CFG         = 6;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_Z   = 3'd5;

    localparam logic [1:0] REGION_BODY  = 2'd0;
    localparam logic [1:0] REGION_START = 2'd1;
    localparam logic [1:0] REGION_END   = 2'd2;
endpackage
`default_nettype wire

// ----- hdl/point_segment_distance_3d.sv -----
`default_nettype none
// Point to segment distance in 3D.
// Configuration: cfg_we/cfg_index/cfg_data write the segment start (index 0..2)
// and end (3..5); write only while no item is in flight. Reset clears them to 0.
// Input: s_axis_* carries one point per item (x, y, z). Output: m_axis_* carries
// distance, closest point and region code per item, in order.
// Throughput: one item per cycle while the output is not stalled. Pipeline:
// registered stages of differences, products, sums, region and the split multiply,
// one divider cell per numerator bit (3*COORD_WIDTH+6 cells, one lane for
// each of the three coordinates in parallel), stages for the closest point
// and squares, one square root cell per result bit (COORD_WIDTH+3 cells) and
// rounding into the output register.
// The whole pipeline advances only when the output register is free or
// being taken, so a stalled receiver holds every item in place and
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module point_segment_distance_3d
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COORD_WIDTH-1:0]     cfg_data,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, zero fill
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // distance, closest_x, closest_y, closest_z, region, zero fill
    output logic [((4*COORD_WIDTH+3+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CW   = COORD_WIDTH;
    localparam int IW   = ((3*CW+7)/8)*8;
    localparam int OW   = ((4*CW+3+7)/8)*8;
    localparam int DW   = CW + 1;            // difference width
    localparam int PW   = 2*DW;              // product width (signed)
    localparam int SUMW = PW + 2;            // sum of three products
    localparam int HW   = SUMW/2;            // low half of num for the split multiply
    localparam int PPW  = HW + DW;           // partial product width
    localparam int NW   = SUMW + DW + 1;     // 2*num*|d| + den, unsigned
    localparam int QW   = DW + 1;            // quotient bits kept
    localparam int NDIV = NW;                // divider cells
    localparam int SQW  = 2*DW + 3;          // sum of squares of errors
    localparam int SQE  = SQW + (SQW % 2);
    localparam int RW   = SQE/2;
    localparam int PRE  = 5;
    localparam int MID  = 2;
    localparam int DEPTH = PRE + NDIV + MID + RW + 1;
    localparam int VD   = DEPTH - 1;

    logic signed [CW-1:0] cfg_reg [NUM_CFG];
    logic [VD-1:0] valid_reg;
    logic adv;
    logic out_valid_reg;

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X: cfg_reg[0] <= cfg_data;
                REG_START_Y: cfg_reg[1] <= cfg_data;
                REG_START_Z: cfg_reg[2] <= cfg_data;
                REG_END_X:   cfg_reg[3] <= cfg_data;
                REG_END_Y:   cfg_reg[4] <= cfg_data;
                REG_END_Z:   cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [VD-1:0] valid_next;
    assign valid_next = {valid_reg[VD-2:0], s_axis_tvalid};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[VD-1];
        end
    end

    // Stage 1: differences
    logic signed [CW-1:0] p1_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= s_axis_tdata[i*CW +: CW];
                e1_reg[i] <= DW'($signed(s_axis_tdata[i*CW +: CW])) - DW'(cfg_reg[i]);
                d1_reg[i] <= DW'(cfg_reg[i+3]) - DW'(cfg_reg[i]);
            end
        end
    end

    // Stage 2: products
    logic signed [PW-1:0] pn2_reg [3];
    logic signed [PW-1:0] pd2_reg [3];
    logic signed [CW-1:0] p2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pn2_reg[i] <= e1_reg[i] * d1_reg[i];
                pd2_reg[i] <= d1_reg[i] * d1_reg[i];
                p2_reg[i]  <= p1_reg[i];
                d2_reg[i]  <= d1_reg[i];
            end
        end
    end

    // Stage 3: sums
    logic signed [SUMW-1:0] num3_reg;
    logic [SUMW-1:0] den3_reg;
    logic signed [CW-1:0] p3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic signed [SUMW-1:0] num_sum;
    logic signed [SUMW-1:0] den_sum;
    always_comb
    begin
        num_sum = SUMW'(pn2_reg[0]) + SUMW'(pn2_reg[1]) + SUMW'(pn2_reg[2]);
        den_sum = SUMW'(pd2_reg[0]) + SUMW'(pd2_reg[1]) + SUMW'(pd2_reg[2]);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num3_reg <= num_sum;
            den3_reg <= den_sum;
            for (int i = 0; i < 3; i++)
            begin
                p3_reg[i] <= p2_reg[i];
                d3_reg[i] <= d2_reg[i];
            end
        end
    end

    // Stage 4: region, num*|d| as two half-width partial products
    logic [1:0] reg4_reg;
    logic [SUMW-1:0] den4_reg;
    logic [PPW-1:0] pl4_reg [3];
    logic [PPW-1:0] ph4_reg [3];
    logic neg4_reg [3];
    logic signed [CW-1:0] p4_reg [3];
    logic [1:0] region_c;
    logic [DW-1:0] mag_c [3];
    always_comb
    begin
        if (den3_reg == '0 || num3_reg[SUMW-1])
            region_c = REGION_START;
        else if ($unsigned(num3_reg) > den3_reg)
            region_c = REGION_END;
        else
            region_c = REGION_BODY;
    end
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_c[i] = $unsigned(d3_reg[i][DW-1] ? -d3_reg[i] : d3_reg[i]);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reg4_reg <= region_c;
            den4_reg <= den3_reg;
            for (int i = 0; i < 3; i++)
            begin
                neg4_reg[i] <= d3_reg[i][DW-1];
                p4_reg[i]   <= p3_reg[i];
                // body only: num in [0, den], so the merged product fits
                pl4_reg[i]  <= PPW'(num3_reg[HW-1:0]) * PPW'(mag_c[i]);
                ph4_reg[i]  <= PPW'(num3_reg[SUMW-1:HW]) * PPW'(mag_c[i]);
            end
        end
    end

    // Stage 5: merge the partial products into the divider operand
    logic [1:0] regm_reg;
    logic [SUMW-1:0] denm_reg;
    logic [NW-1:0] mm_reg [3];
    logic negm_reg [3];
    logic signed [CW-1:0] pm_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            regm_reg <= reg4_reg;
            denm_reg <= den4_reg;
            for (int i = 0; i < 3; i++)
            begin
                negm_reg[i] <= neg4_reg[i];
                pm_reg[i]   <= p4_reg[i];
                mm_reg[i]   <= (NW'(ph4_reg[i]) << HW) + NW'(pl4_reg[i]);
            end
        end
    end

    // Divider chain: q = (2m + den) / (2 den)
    logic [NW-1:0]   dn [3][NDIV+1];
    logic [NW:0]     dr [3][NDIV+1];
    logic [QW-1:0]   dq [3][NDIV+1];
    logic [NW-1:0]   dd [3][NDIV+1];
    logic [1:0]      rg_pipe [NDIV+1];
    logic signed [CW-1:0] pp_pipe [3][NDIV+1];
    logic            ng_pipe [3][NDIV+1];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        assign dn[k][0] = (mm_reg[k] << 1) + NW'(denm_reg);
        assign dr[k][0] = '0;
        assign dq[k][0] = '0;
        assign dd[k][0] = NW'(denm_reg) << 1;
        assign pp_pipe[k][0] = pm_reg[k];
        assign ng_pipe[k][0] = negm_reg[k];
        for (genvar j = 0; j < NDIV; j++)
        begin : g_cell
            psd_div_cell #(.NW(NW), .DW(NW), .QW(QW)) u_cell (
                .clk     (clk),
                .en      (adv),
                .rem_in  (dr[k][j]),
                .num_in  (dn[k][j]),
                .quo_in  (dq[k][j]),
                .den_in  (dd[k][j]),
                .rem_out (dr[k][j+1]),
                .num_out (dn[k][j+1]),
                .quo_out (dq[k][j+1]),
                .den_out (dd[k][j+1])
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pp_pipe[k][j+1] <= pp_pipe[k][j];
                    ng_pipe[k][j+1] <= ng_pipe[k][j];
                end
            end
        end
    end
    assign rg_pipe[0] = regm_reg;
    for (genvar j = 0; j < NDIV; j++)
    begin : g_rgp
        always_ff @(posedge clk)
        begin
            if (adv)
                rg_pipe[j+1] <= rg_pipe[j];
        end
    end

    // Mid stage 1: closest point and error
    logic signed [CW-1:0] c5_reg [3];
    logic signed [DW-1:0] e5_reg [3];
    logic [1:0] rg5_reg;
    logic signed [CW-1:0] cpt [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (rg_pipe[NDIV])
                REGION_START: cpt[i] = cfg_reg[i];
                REGION_END:   cpt[i] = cfg_reg[i+3];
                default:      cpt[i] = cfg_reg[i] + (ng_pipe[i][NDIV]
                                  ? -CW'(dq[i][NDIV]) : CW'(dq[i][NDIV]));
            endcase
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rg5_reg <= rg_pipe[NDIV];
            for (int i = 0; i < 3; i++)
            begin
                c5_reg[i] <= cpt[i];
                e5_reg[i] <= DW'(pp_pipe[i][NDIV]) - DW'(cpt[i]);
            end
        end
    end

    // Mid stage 2: sum of squares
    logic [SQE-1:0] s6_reg;
    logic signed [CW-1:0] c6_reg [3];
    logic [1:0] rg6_reg;
    logic signed [PW-1:0] sq5 [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq5[i] = e5_reg[i] * e5_reg[i];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_reg  <= SQE'($unsigned(sq5[0]))
                     + SQE'($unsigned(sq5[1]))
                     + SQE'($unsigned(sq5[2]));
            rg6_reg <= rg5_reg;
            for (int i = 0; i < 3; i++)
                c6_reg[i] <= c5_reg[i];
        end
    end

    // Square root chain
    logic [SQE-1:0] sr_rad [RW+1];
    logic [RW+1:0]  sr_rem [RW+1];
    logic [RW-1:0]  sr_root [RW+1];
    logic [3*CW+1:0] side_pipe [RW+1];
    assign sr_rad[0]  = s6_reg;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;
    assign side_pipe[0] = {rg6_reg, c6_reg[2], c6_reg[1], c6_reg[0]};
    for (genvar j = 0; j < RW; j++)
    begin : g_sq
        psd_sqrt_cell #(.SW(SQE), .RW(RW)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sr_rad[j]),
            .rem_in   (sr_rem[j]),
            .root_in  (sr_root[j]),
            .rad_out  (sr_rad[j+1]),
            .rem_out  (sr_rem[j+1]),
            .root_out (sr_root[j+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
                side_pipe[j+1] <= side_pipe[j];
        end
    end

    // Round (remainder > root means up) and saturate
    logic [RW:0] rnd;
    logic [DW-1:0] dist_c;
    always_comb
    begin
        rnd = {1'b0, sr_root[RW]} + ((RW+2)'(sr_rem[RW]) > (RW+2)'(sr_root[RW]) ? 1'b1 : 1'b0);
        dist_c = (rnd > (RW+1)'({DW{1'b1}})) ? {DW{1'b1}} : DW'(rnd);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            m_axis_tdata <= OW'({side_pipe[RW][3*CW+1:3*CW],
                                 side_pipe[RW][3*CW-1:0], dist_c});
    end
endmodule
`default_nettype wire

// ----- hdl/psd_div_cell.sv -----
`default_nettype none
// One restoring-division step: shift in the next numerator bit, subtract if it fits.
module psd_div_cell #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW:0]   rem_in,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [QW-1:0] quo_in,
    input  wire logic [DW-1:0] den_in,
    output logic      [DW:0]   rem_out,
    output logic      [NW-1:0] num_out,
    output logic      [QW-1:0] quo_out,
    output logic      [DW-1:0] den_out
);
    logic [DW+1:0] trial;
    logic [DW+1:0] shifted;
    assign shifted = {rem_in, num_in[NW-1]};
    assign trial   = shifted - {1'b0, 1'b0, den_in};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= trial[DW+1] ? shifted[DW:0] : trial[DW:0];
            num_out <= {num_in[NW-2:0], 1'b0};
            quo_out <= {quo_in[QW-2:0], ~trial[DW+1]};
            den_out <= den_in;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/psd_sqrt_cell.sv -----
`default_nettype none
// One digit-by-digit square root step, two radicand bits per cell.
module psd_sqrt_cell #(
    parameter int SW = 8,
    parameter int RW = 4
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [SW-1:0] rad_in,
    input  wire logic [RW+1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic      [SW-1:0] rad_out,
    output logic      [RW+1:0] rem_out,
    output logic      [RW-1:0] root_out
);
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    assign cur   = {rem_in, rad_in[SW-1:SW-2]};
    assign trial = cur - {2'b00, root_in, 2'b01};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out  <= {rad_in[SW-3:0], 2'b00};
            rem_out  <= trial[RW+3] ? cur[RW+1:0] : trial[RW+1:0];
            root_out <= {root_in[RW-2:0], ~trial[RW+3]};
        end
    end
endmodule
`default_nettype wire

// ----- hdl/psd_checker.sv -----
`default_nettype none
module psd_checker
    import psd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("ready while stalled");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("data moved");
    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[130:129] <= REGION_END) else $error("bad region");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("not ready when empty");
endmodule
bind point_segment_distance_3d psd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
